// File: rtl/core/idrm_pkg.sv
`timescale 1ns / 1ps

package idrm_pkg;

	// command codes on the cmd field
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_OVERFLOW   = 3'd2;
	localparam logic [2:0] ST_OVERLAP    = 3'd3;
	localparam logic [2:0] ST_NOT_MAPPED = 3'd4;

	// source of the result host id
	localparam logic [1:0] HS_ZERO = 2'd0;
	localparam logic [1:0] HS_CONT = 2'd1;
	localparam logic [1:0] HS_MAP  = 2'd2;

	// one stored range
	typedef struct packed {
		logic [31:0] cont_start;
		logic [31:0] host_start;
		logic [31:0] length;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       idx_clr;
		logic       idx_inc;
		logic       wr;
		logic       res_we;
		logic [2:0] res_code;
		logic [1:0] host_sel;
		logic       out_load;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_add;
		logic full;
		logic ovf;
		logic empty;
		logic hit;
		logic last;
		logic out_hold;
	} dp_stat_t;

endpackage

// File: rtl/core/id_range_map_table_unit.sv
`timescale 1ns / 1ps
// range-based id translation, one table for user ids and one for group ids
// input channel: in_valid / in_stall carry cmd, map_select, cont_id,
//   host_start and range_len; a transfer happens when in_valid is high and
//   in_stall low. cmd add appends a range, cmd translate looks one id up
// output channel: out_valid / out_stall carry status and host_id, one
//   result per input transfer, in order
// timing: items are worked one at a time. after the input transfer the
//   controller runs the early checks, then walks stored entries one by one
//   through the single comparator, then loads the output register; no walk
//   is needed when the early checks settle the item, and at most the whole
//   table is walked. the walk is set by the one-entry-per-cycle read port
//   of the entry ram
// a finished result sits in the output register while the next item is
//   taken in; if the receiver keeps out_stall high, the next result waits
//   in the result registers and in_stall stays high until the register frees up
// reset: entry counts of both tables go to zero and the output is empty;
//   the entry ram itself needs no clearing since only counted entries are read

module id_range_map_table_unit #(
	parameter int MAX_ENTRIES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic        map_select,
	input  logic [31:0] cont_id,
	input  logic [31:0] host_start,
	input  logic [31:0] range_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] host_id
);

	import idrm_pkg::*;

	// command and status between controller and datapath
	ctl_cmd_t ctl;
	dp_stat_t stat;

	// state machine: idle, early checks, entry walk, output load
	idrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// item registers, entry ram, comparator, counts and output register
	idrm_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.map_select (map_select),
		.cont_id    (cont_id),
		.host_start (host_start),
		.range_len  (range_len),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.host_id    (host_id),
		.ctl        (ctl),
		.stat       (stat)
	);

endmodule

// File: rtl/core/idrm_ram.sv
`timescale 1ns / 1ps

module idrm_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/idrm_ctrl.sv
`timescale 1ns / 1ps

module idrm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  idrm_pkg::dp_stat_t  stat,
	output idrm_pkg::ctl_cmd_t  ctl
);

	import idrm_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_WALK  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.res_code = ST_OK;
		ctl.host_sel = HS_ZERO;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.idx_clr = 1'b1;
				if (stat.is_add) begin
					if (stat.full) begin
						ctl.res_we   = 1'b1;
						ctl.res_code = ST_FULL;
						state_d      = S_DONE;
					end else if (stat.ovf) begin
						ctl.res_we   = 1'b1;
						ctl.res_code = ST_OVERFLOW;
						state_d      = S_DONE;
					end else if (stat.empty) begin
						ctl.wr     = 1'b1;
						ctl.res_we = 1'b1;
						state_d    = S_DONE;
					end else begin
						state_d = S_WALK;
					end
				end else if (stat.empty) begin
					ctl.res_we   = 1'b1;
					ctl.host_sel = HS_CONT;
					state_d      = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.hit) begin
					ctl.res_we = 1'b1;
					if (stat.is_add) begin
						ctl.res_code = ST_OVERLAP;
					end else begin
						ctl.host_sel = HS_MAP;
					end
					state_d = S_DONE;
				end else if (stat.last) begin
					ctl.res_we = 1'b1;
					if (stat.is_add) begin
						ctl.wr = 1'b1;
					end else begin
						ctl.res_code = ST_NOT_MAPPED;
					end
					state_d = S_DONE;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			S_DONE: begin
				if (!stat.out_hold) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/idrm_dp.sv
`timescale 1ns / 1ps

module idrm_dp #(
	parameter int MAX_ENTRIES = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd,
	input  logic               map_select,
	input  logic [31:0]        cont_id,
	input  logic [31:0]        host_start,
	input  logic [31:0]        range_len,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [2:0]         status,
	output logic [31:0]        host_id,
	input  idrm_pkg::ctl_cmd_t ctl,
	output idrm_pkg::dp_stat_t stat
);

	import idrm_pkg::*;

	localparam int IDXW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
	localparam int AW    = IDXW + 1;
	localparam int DEPTH = 2 << IDXW;

	// latched item
	logic        cmd_q;
	logic        sel_q;
	logic [31:0] cont_q;
	logic [31:0] host_q;
	logic [31:0] len_q;

	logic [1:0][CNTW-1:0] cnt_q;
	logic [CNTW-1:0]      cnt;
	logic [IDXW-1:0]      idx_q;
	logic [IDXW-1:0]      idx_d;

	entry_t      rd_ent;
	entry_t      wr_ent;
	logic [31:0] cont_end;
	logic [31:0] host_end;
	logic        cont_in;
	logic        host_in;
	logic [31:0] mapped;

	logic [2:0]  res_status_q;
	logic [31:0] res_host_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] host_id_q;

	assign cnt = cnt_q[sel_q];

	always_comb begin
		if (ctl.idx_clr) begin
			idx_d = '0;
		end else if (ctl.idx_inc) begin
			idx_d = idx_q + IDXW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	assign wr_ent.cont_start = cont_q;
	assign wr_ent.host_start = host_q;
	assign wr_ent.length     = len_q;

	idrm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.wr),
		.waddr ({sel_q, cnt[IDXW-1:0]}),
		.wdata (wr_ent),
		.raddr (AW'({sel_q, idx_d})),
		.rdata (rd_ent)
	);

	// range checks on the entry read out, end point wraps at 32 bits
	assign cont_end = rd_ent.cont_start + rd_ent.length - 32'd1;
	assign host_end = rd_ent.host_start + rd_ent.length - 32'd1;
	assign cont_in  = (rd_ent.cont_start <= cont_q) && (cont_q <= cont_end);
	assign host_in  = (rd_ent.host_start <= host_q) && (host_q <= host_end);
	assign mapped   = rd_ent.host_start + (cont_q - rd_ent.cont_start);

	assign stat.is_add   = (cmd_q == CMD_ADD);
	assign stat.full     = (cnt >= CNTW'(MAX_ENTRIES));
	assign stat.ovf      = (cont_q > ~len_q) || (host_q > ~len_q);
	assign stat.empty    = (cnt == '0);
	assign stat.hit      = cont_in || (stat.is_add && host_in);
	assign stat.last     = ((CNTW'(idx_q) + CNTW'(1)) == cnt);
	assign stat.out_hold = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			sel_q  <= map_select;
			cont_q <= cont_id;
			host_q <= host_start;
			len_q  <= range_len;
		end
		idx_q <= idx_d;
		if (ctl.res_we) begin
			res_status_q <= ctl.res_code;
			case (ctl.host_sel)
				HS_CONT: res_host_q <= cont_q;
				HS_MAP:  res_host_q <= mapped;
				default: res_host_q <= '0;
			endcase
		end
		if (ctl.out_load) begin
			status_q  <= res_status_q;
			host_id_q <= res_host_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.wr) begin
				cnt_q[sel_q] <= cnt + CNTW'(1);
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign host_id   = host_id_q;

endmodule

// File: rtl/core/idrm_chk.sv
`timescale 1ns / 1ps

module idrm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] host_id
);

	import idrm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(host_id))
		else $error("stalled result changed");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_OVERFLOW ||
			status == ST_OVERLAP || status == ST_NOT_MAPPED))
		else $error("undefined status code");

	// every error result carries a zero host id
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> host_id == 32'd0)
		else $error("error result with nonzero host id");

	// one item at a time: an input transfer closes the input for a while
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input reopened too early");

endmodule

bind id_range_map_table_unit idrm_chk u_idrm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.host_id   (host_id)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

	import idrm_pkg::*;

	localparam int TABLE_DEPTH    = 5;
	localparam int RANDOM_ITEMS   = 1925;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 16;

	// table selector values on map_select
	localparam logic SEL_UID = 1'b0;
	localparam logic SEL_GID = 1'b1;

	// mirror of both range tables, plus the queue of results still owed by the block
	class id_map_tracker;
		logic [31:0] cont_lo [2][TABLE_DEPTH];
		logic [31:0] host_lo [2][TABLE_DEPTH];
		logic [31:0] span    [2][TABLE_DEPTH];
		int          fill    [2];
		logic [2:0]  due_status[$];
		logic [31:0] due_host[$];
		int          errors;
		int          replies;
		int          status_seen[5];

		function new();
			fill[0] = 0;
			fill[1] = 0;
			errors  = 0;
			replies = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// inclusive range test, end point wraps at 32 bits
		function bit covers(logic [31:0] lo, logic [31:0] len, logic [31:0] v);
			logic [31:0] hi;
			hi = lo + len - 32'd1;
			return (lo <= v) && (v <= hi);
		endfunction

		function logic [2:0] predict_add(int t, logic [31:0] c, logic [31:0] h,
				logic [31:0] n);
			logic [31:0] lim;
			lim = 32'hFFFF_FFFF - n;
			if (fill[t] >= TABLE_DEPTH) return ST_FULL;
			if (c > lim || h > lim) return ST_OVERFLOW;
			for (int i = 0; i < fill[t]; i++) begin
				if (covers(cont_lo[t][i], span[t][i], c) ||
						covers(host_lo[t][i], span[t][i], h))
					return ST_OVERLAP;
			end
			cont_lo[t][fill[t]] = c;
			host_lo[t][fill[t]] = h;
			span[t][fill[t]]    = n;
			fill[t]++;
			return ST_OK;
		endfunction

		function void note_command(logic op, logic sel, logic [31:0] cid,
				logic [31:0] hs, logic [31:0] n);
			logic [2:0]  st;
			logic [31:0] hid;
			int          t;
			bit          found;
			t     = sel;
			hid   = '0;
			found = 1'b0;
			if (op == CMD_ADD) begin
				st = predict_add(t, cid, hs, n);
			end else if (fill[t] == 0) begin
				st  = ST_OK;
				hid = cid;
			end else begin
				st = ST_NOT_MAPPED;
				for (int i = 0; i < fill[t]; i++) begin
					if (!found && covers(cont_lo[t][i], span[t][i], cid)) begin
						found = 1'b1;
						st    = ST_OK;
						hid   = host_lo[t][i] + (cid - cont_lo[t][i]);
					end
				end
			end
			due_status.push_back(st);
			due_host.push_back(hid);
			status_seen[st]++;
		endfunction

		function void check_reply(logic [2:0] st, logic [31:0] hid);
			logic [2:0]  want_st;
			logic [31:0] want_host;
			if (due_status.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d host_id %h",
					$time, st, hid);
				errors++;
				return;
			end
			want_st   = due_status.pop_front();
			want_host = due_host.pop_front();
			replies++;
			if (st !== want_st) begin
				$display("%0t: status expected %0d, actual %0d", $time, want_st, st);
				errors++;
			end
			if (hid !== want_host) begin
				$display("%0t: host_id expected %h, actual %h", $time, want_host, hid);
				errors++;
			end
		endfunction
	endclass

	// clock, reset and block ports; every port the bench drives is known from time zero
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        cmd        = CMD_ADD;
	logic        map_select = SEL_UID;
	logic [31:0] cont_id    = '0;
	logic [31:0] host_start = '0;
	logic [31:0] range_len  = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [2:0]  status;
	logic [31:0] host_id;

	// set during the stretch where neither side idles
	logic        quiet      = 1'b0;
	int          idle_run   = 0;
	int          sent       = 0;

	id_map_tracker track = new();

	always #4 clk = ~clk;

	id_range_map_table_unit #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.map_select(map_select),
		.cont_id   (cont_id),
		.host_start(host_start),
		.range_len (range_len),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.host_id   (host_id)
	);

	// one input transfer: optional idle cycles first, then hold the payload until taken
	task automatic send_item(input logic op, input logic sel, input logic [31:0] cid,
			input logic [31:0] hs, input logic [31:0] n);
		while (!quiet && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		map_select <= sel;
		cont_id    <= cid;
		host_start <= hs;
		range_len  <= n;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// transfer taken at this edge, so the prediction is made now
		track.note_command(op, sel, cid, hs, n);
		sent++;
	endtask

	// drop valid and hold off until every owed result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (track.due_status.size() != 0) @(posedge clk);
	endtask

	// container id aimed at the edges of a stored range, or anywhere at all
	function automatic logic [31:0] pick_cont(logic sel);
		int          t;
		int          k;
		logic [31:0] lo;
		logic [31:0] len;
		t = sel;
		if (track.fill[t] == 0 || $urandom_range(0, 5) == 0) return $urandom;
		k   = $urandom_range(0, track.fill[t] - 1);
		lo  = track.cont_lo[t][k];
		len = track.span[t][k];
		case ($urandom_range(0, 4))
			0: return lo;
			1: return lo + len - 32'd1;
			2: return lo + len;
			3: return lo - 32'd1;
			default: return (len == 0) ? lo : lo + ($urandom % len);
		endcase
	endfunction

	// lengths: tiny, moderate, anything, and right at the overflow edge
	function automatic logic [31:0] pick_len();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 16);
			1: return $urandom_range(0, 32'h0001_0000);
			2: return $urandom;
			default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
		endcase
	endfunction

	// result side: check each output transfer, random back-pressure, watchdog
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (!arst_n) begin
			out_stall <= 1'b0;
			idle_run  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				track.check_reply(status, host_id);
				moved = 1'b1;
			end
			if (in_valid && !in_stall) moved = 1'b1;
			if (moved) begin
				idle_run <= 0;
			end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_run <= idle_run + 1;
			end
			out_stall <= !quiet && ($urandom_range(0, 99) < 22);
		end
	end

	initial begin
		logic        op;
		logic        sel;
		logic [31:0] cid;
		logic [31:0] hs;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tables hand the id straight back
		send_item(CMD_XLATE, SEL_UID, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_XLATE, SEL_GID, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);

		// user table: good range, both overflow sides, both overlap sides
		send_item(CMD_ADD, SEL_UID, 32'h0000_1000, 32'h8000_0000, 32'h0000_0100);
		send_item(CMD_ADD, SEL_UID, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
		send_item(CMD_ADD, SEL_UID, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(CMD_ADD, SEL_UID, 32'h0000_10FF, 32'h0000_0010, 32'h0000_0004);
		send_item(CMD_ADD, SEL_UID, 32'h0000_0020, 32'h8000_00FF, 32'h0000_0004);
		// adjacent range, then a zero-length range that covers nothing
		send_item(CMD_ADD, SEL_UID, 32'h0000_1100, 32'h8000_0100, 32'h0000_FFFF);
		send_item(CMD_ADD, SEL_UID, 32'h0000_0007, 32'h0000_0007, 32'h0000_0000);
		// zero length at zero wraps round and covers every id
		send_item(CMD_ADD, SEL_UID, 32'h0000_0000, 32'h4000_0000, 32'h0000_0000);
		send_item(CMD_ADD, SEL_UID, 32'h0005_0000, 32'h0005_0000, 32'h0000_0001);
		send_item(CMD_ADD, SEL_UID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// lookups: range ends, the catch-all entry and a wrapped host id
		send_item(CMD_XLATE, SEL_UID, 32'h0000_1000, 32'h0, 32'h0);
		send_item(CMD_XLATE, SEL_UID, 32'h0000_10FF, 32'h0, 32'h0);
		send_item(CMD_XLATE, SEL_UID, 32'h0000_1100, 32'h0, 32'h0);
		send_item(CMD_XLATE, SEL_UID, 32'h0000_0007, 32'h0, 32'h0);
		send_item(CMD_XLATE, SEL_UID, 32'hFFFF_FFFF, 32'h0, 32'h0);

		// group table filled to the brim, top range ending at the overflow edge
		send_item(CMD_ADD, SEL_GID, 32'hFFFF_FFEF, 32'h0000_0010, 32'h0000_0010);
		send_item(CMD_ADD, SEL_GID, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0001);
		send_item(CMD_ADD, SEL_GID, 32'h0000_0100, 32'h0000_0200, 32'h0000_0100);
		send_item(CMD_ADD, SEL_GID, 32'h0000_0300, 32'h0000_0100, 32'h0000_0100);
		send_item(CMD_ADD, SEL_GID, 32'h8000_0000, 32'h9000_0000, 32'h1000_0000);
		send_item(CMD_ADD, SEL_GID, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
		send_item(CMD_XLATE, SEL_GID, 32'hFFFF_FFFE, 32'h0, 32'h0);
		send_item(CMD_XLATE, SEL_GID, 32'h0000_0400, 32'h0, 32'h0);
		drain_results();

		// random traffic, mostly lookups aimed at the stored ranges
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300) quiet <= 1'b1;
			if (i == 600) quiet <= 1'b0;
			if (i == 1000) drain_results();
			sel = 1'($urandom_range(0, 1));
			op  = ($urandom_range(0, 99) < 30) ? CMD_ADD : CMD_XLATE;
			cid = (op == CMD_ADD && $urandom_range(0, 1) == 1) ? $urandom : pick_cont(sel);
			hs  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 16) :
				$urandom;
			send_item(op, sel, cid, hs, pick_len());
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d transfers in, %0d results checked, %0d errors", sent, track.replies,
			track.errors);
		$display("status mix: ok %0d, full %0d, overflow %0d, overlap %0d, not mapped %0d",
			track.status_seen[ST_OK], track.status_seen[ST_FULL],
			track.status_seen[ST_OVERFLOW], track.status_seen[ST_OVERLAP],
			track.status_seen[ST_NOT_MAPPED]);
		if (track.errors == 0 && track.due_status.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
